// ===== src/svt_pkg.sv =====
// Package for the 3x3 Sauvola threshold block: item types, constants and helpers.
package svt_pkg;

  localparam int unsigned PixW    = 8;
  localparam int unsigned NumPix  = 9;
  localparam int unsigned SumW    = 12;
  localparam int unsigned SqW     = 16;
  localparam int unsigned DevW    = 20;
  localparam int unsigned QuoW    = 17;
  localparam int unsigned FracW   = 16;
  localparam int unsigned RadW    = 1 + QuoW + FracW;
  localparam int unsigned RootW   = RadW / 2;
  localparam int unsigned RemW    = RootW + 2;
  localparam int unsigned SqBits  = 2;
  localparam int unsigned SqStg   = (RootW + SqBits - 1) / SqBits;
  localparam int unsigned KW      = 16;
  localparam int unsigned PW      = 34;
  localparam int unsigned NumW    = 43;
  localparam int unsigned ThrShft = 27;

  localparam logic [12:0]        MeanRecip = 13'd7282;
  localparam logic [20:0]        DevRecip  = 21'd1864136;
  localparam logic signed [15:0] KReset    = 16'sd819;
  localparam logic [PixW-1:0]    ThrMax    = 8'd255;

  typedef struct packed {
    logic [7:0] win_r0c0;
    logic [7:0] win_r0c1;
    logic [7:0] win_r0c2;
    logic [7:0] win_r1c0;
    logic [7:0] win_r1c1;
    logic [7:0] win_r1c2;
    logic [7:0] win_r2c0;
    logic [7:0] win_r2c1;
    logic [7:0] win_r2c2;
    logic [8:0] present_mask;
  } svt_in_t;

  typedef struct packed {
    logic [7:0] local_threshold;
    logic       pixel_white;
  } svt_out_t;

  typedef struct packed {
    logic [PixW-1:0] mean;
    logic [PixW-1:0] ctr;
  } svt_side_t;

  // floor(r * 65536 / 9) for a remainder r of a division by nine
  function automatic logic [FracW-1:0] svt_ninth_frac(input logic [3:0] r);
    logic [FracW-1:0] f;
    unique case (r)
      4'd0:    f = 16'd0;
      4'd1:    f = 16'd7281;
      4'd2:    f = 16'd14563;
      4'd3:    f = 16'd21845;
      4'd4:    f = 16'd29127;
      4'd5:    f = 16'd36408;
      4'd6:    f = 16'd43690;
      4'd7:    f = 16'd50972;
      4'd8:    f = 16'd58254;
      default: f = 16'd0;
    endcase
    return f;
  endfunction

endpackage

// ===== src/sauvola_threshold_3x3.sv =====
// Sauvola local threshold over a 3x3 window of 8-bit gray pixels; fully pipelined.
//
// Takes one window item per clock and returns one result item per window. Six stages form
// the masked sum, the mean, the squared deviations, their sum and the exact division by
// nine; nine stages take the square root two result bits each, one in the last; two
// multiply stages and an output register form and clamp the threshold. The output
// register belongs to the pipeline: when a result waits, the whole pipeline holds and
// in_ready_o drops until the result is taken. The sensitivity register is taken at any
// cycle (cfg_ready_o is always high) and is meant to change only while no item is inside.
module sauvola_threshold_3x3 (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  svt_pkg::svt_in_t        in_data_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output svt_pkg::svt_out_t       out_data_o,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic signed [15:0]      cfg_data_i
);
  import svt_pkg::*;

  localparam int unsigned SMean  = 1;
  localparam int unsigned SDiv   = 4;
  localparam int unsigned SRoot0 = 6;
  localparam int unsigned SRootL = SRoot0 + SqStg - 1;
  localparam int unsigned NumStg = SRootL + 4;
  localparam int unsigned SOut   = NumStg - 1;

  logic                   en;
  logic [NumStg-1:0]      vld_q, vld_d;
  logic signed [KW-1:0]   k_q;

  logic [PixW-1:0]        px_in [NumPix];
  logic [PixW-1:0]        s1_px_q [NumPix];
  logic [NumPix-1:0]      s1_mask_q;
  logic [SumW-1:0]        s1_sum_q, s1_sum_d;
  logic [PixW-1:0]        s1_ctr_q;

  logic [24:0]            mean_prod;
  logic [PixW-1:0]        s2_px_q [NumPix];
  logic [NumPix-1:0]      s2_mask_q;
  logic [PixW-1:0]        s2_m_q;
  logic [PixW-1:0]        s2_ctr_q;

  logic [SqW-1:0]         s3_sq_q [NumPix];
  logic [SqW-1:0]         s3_sq_d [NumPix];
  svt_side_t              s3_side_q;

  logic [DevW-1:0]        s4_dev_q, s4_dev_d;
  svt_side_t              s4_side_q;

  logic [40:0]            div_prod;
  logic [QuoW-1:0]        s5_a_q;
  logic [DevW-1:0]        s5_dev_q;
  svt_side_t              s5_side_q;

  logic [DevW-1:0]        nine_a;
  logic [DevW-1:0]        rad_rem;
  logic [RadW-1:0]        s6_rad_q;
  svt_side_t              s6_side_q;

  logic [RemW-1:0]        rem_src [SqStg];
  logic [RootW-1:0]       root_src [SqStg];
  logic [RadW-1:0]        rad_src [SqStg];
  logic [RemW-1:0]        sq_rem_d [SqStg];
  logic [RootW-1:0]       sq_root_d [SqStg];
  logic [RadW-1:0]        sq_rad_d [SqStg];
  logic [RemW-1:0]        sq_rem_q [SqStg];
  logic [RootW-1:0]       sq_root_q [SqStg];
  logic [RadW-1:0]        sq_rad_q [SqStg-1];
  svt_side_t              sq_side_q [SqStg];

  logic signed [RootW:0]  dlt;
  logic signed [PW-1:0]   mu_prod;
  logic signed [PW-1:0]   mu1_p_q;
  svt_side_t              mu1_side_q;

  logic signed [NumW-1:0] mu2_num_d, mu2_num_q;
  logic [PixW-1:0]        mu2_ctr_q;

  logic [NumW-ThrShft-1:0] thr_hi;
  logic [PixW-1:0]        thr;
  svt_out_t               out_q, out_d;

  assign en          = !vld_q[SOut] || out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = vld_q[SOut];
  assign out_data_o  = out_q;
  assign cfg_ready_o = 1'b1;
  assign vld_d       = {vld_q[NumStg-2:0], in_valid_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      k_q   <= KReset;
    end else begin
      if (en) begin
        vld_q <= vld_d;
      end
      if (cfg_valid_i) begin
        k_q <= cfg_data_i;
      end
    end
  end

  assign px_in[0] = in_data_i.win_r0c0;
  assign px_in[1] = in_data_i.win_r0c1;
  assign px_in[2] = in_data_i.win_r0c2;
  assign px_in[3] = in_data_i.win_r1c0;
  assign px_in[4] = in_data_i.win_r1c1;
  assign px_in[5] = in_data_i.win_r1c2;
  assign px_in[6] = in_data_i.win_r2c0;
  assign px_in[7] = in_data_i.win_r2c1;
  assign px_in[8] = in_data_i.win_r2c2;

  always_comb begin
    s1_sum_d = '0;
    for (int i = 0; i < NumPix; i++) begin
      if (in_data_i.present_mask[i]) begin
        s1_sum_d = s1_sum_d + SumW'(px_in[i]);
      end
    end
  end

  assign mean_prod = 25'(s1_sum_q) * 25'(MeanRecip);

  always_comb begin
    logic signed [PixW:0]   d;
    logic signed [2*PixW+1:0] dd;
    for (int i = 0; i < NumPix; i++) begin
      d  = $signed({1'b0, s2_px_q[i]}) - $signed({1'b0, s2_m_q});
      dd = d * d;
      s3_sq_d[i] = s2_mask_q[i] ? dd[SqW-1:0] : '0;
    end
  end

  always_comb begin
    s4_dev_d = '0;
    for (int i = 0; i < NumPix; i++) begin
      s4_dev_d = s4_dev_d + DevW'(s3_sq_q[i]);
    end
  end

  assign div_prod = 41'(s4_dev_q) * 41'(DevRecip);
  assign nine_a   = {s5_a_q, 3'b000} + DevW'(s5_a_q);
  assign rad_rem  = s5_dev_q - nine_a;

  always_comb begin
    logic [RemW-1:0]  rem;
    logic [RootW-1:0] root;
    logic [RadW-1:0]  rad;
    logic [RemW-1:0]  rem_t;
    logic [RemW-1:0]  trial;
    rem_src[0]  = '0;
    root_src[0] = '0;
    rad_src[0]  = s6_rad_q;
    for (int k = 1; k < SqStg; k++) begin
      rem_src[k]  = sq_rem_q[k-1];
      root_src[k] = sq_root_q[k-1];
      rad_src[k]  = sq_rad_q[k-1];
    end
    for (int k = 0; k < SqStg; k++) begin
      rem  = rem_src[k];
      root = root_src[k];
      rad  = rad_src[k];
      for (int j = 0; j < SqBits; j++) begin
        if (k * SqBits + j < RootW) begin
          rem_t = {rem[RemW-3:0], rad[RadW-1 -: 2]};
          trial = {root, 2'b01};
          if (rem_t >= trial) begin
            rem  = rem_t - trial;
            root = {root[RootW-2:0], 1'b1};
          end else begin
            rem  = rem_t;
            root = {root[RootW-2:0], 1'b0};
          end
          rad = {rad[RadW-3:0], 2'b00};
        end
      end
      sq_rem_d[k]  = rem;
      sq_root_d[k] = root;
      sq_rad_d[k]  = rad;
    end
  end

  assign dlt       = $signed({1'b0, sq_root_q[SqStg-1]}) - $signed((RootW+1)'(32768));
  assign mu_prod   = k_q * dlt;
  assign mu2_num_d = $signed({1'b0, mu1_side_q.mean}) * mu1_p_q;
  assign thr_hi    = mu2_num_q[NumW-1:ThrShft];

  always_comb begin
    if (mu2_num_q[NumW-1] || (mu2_num_q == '0)) begin
      thr = '0;
    end else if (thr_hi > (NumW-ThrShft)'(ThrMax)) begin
      thr = ThrMax;
    end else begin
      thr = thr_hi[PixW-1:0];
    end
    out_d.local_threshold = thr;
    out_d.pixel_white     = (mu2_ctr_q > thr);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < NumPix; i++) begin
        s1_px_q[i] <= px_in[i];
        s2_px_q[i] <= s1_px_q[i];
        s3_sq_q[i] <= s3_sq_d[i];
      end
      s1_mask_q <= in_data_i.present_mask;
      s1_sum_q  <= s1_sum_d;
      s1_ctr_q  <= in_data_i.win_r1c1;

      s2_mask_q <= s1_mask_q;
      s2_m_q    <= mean_prod[23:16];
      s2_ctr_q  <= s1_ctr_q;

      s3_side_q.mean <= s2_m_q;
      s3_side_q.ctr  <= s2_ctr_q;

      s4_dev_q  <= s4_dev_d;
      s4_side_q <= s3_side_q;

      s5_a_q    <= div_prod[40:24];
      s5_dev_q  <= s4_dev_q;
      s5_side_q <= s4_side_q;

      s6_rad_q  <= {1'b0, s5_a_q, svt_ninth_frac(rad_rem[3:0])};
      s6_side_q <= s5_side_q;

      for (int k = 0; k < SqStg; k++) begin
        sq_rem_q[k]  <= sq_rem_d[k];
        sq_root_q[k] <= sq_root_d[k];
      end
      for (int k = 0; k < SqStg - 1; k++) begin
        sq_rad_q[k] <= sq_rad_d[k];
      end
      sq_side_q[0] <= s6_side_q;
      for (int k = 1; k < SqStg; k++) begin
        sq_side_q[k] <= sq_side_q[k-1];
      end

      mu1_p_q    <= mu_prod + $signed(PW'(1) << ThrShft);
      mu1_side_q <= sq_side_q[SqStg-1];

      mu2_num_q <= mu2_num_d;
      mu2_ctr_q <= mu1_side_q.ctr;

      out_q <= out_d;
    end
  end

  a_mean_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[SMean] && $past(en)) |->
      ((13'(s2_m_q) * 13'd9 <= 13'($past(s1_sum_q))) &&
       (13'($past(s1_sum_q)) < 13'(s2_m_q) * 13'd9 + 13'd9)))
    else $error("mean is not the floor of sum by nine");

  a_div_exact: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[SDiv] |-> ((nine_a <= s5_dev_q) && (rad_rem < DevW'(9))))
    else $error("deviation quotient by nine is off");

  a_root_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[SRootL] |-> (sq_rem_q[SqStg-1] <= {1'b0, sq_root_q[SqStg-1], 1'b0}))
    else $error("square root remainder exceeds twice the root");

endmodule

// ===== verif/tb_sauvola_threshold_3x3.sv =====
// Testbench for sauvola_threshold_3x3: directed table and random windows against a predictor.
`timescale 1ns / 100ps

module tb_sauvola_threshold_3x3;
  import svt_pkg::*;

  localparam int PipeLat  = 20;
  localparam int CycLimit = 300000;
  localparam int NumDir   = 25;
  localparam int NumRand  = 131;

  typedef struct packed {
    logic signed [15:0] k;
    svt_in_t            win;
    bit                 typed;
    svt_out_t           res;
  } dir_row_t;

  localparam logic [7:0][8:0] EdgeMask = {9'h1B0, 9'h0D8, 9'h01B, 9'h036,
                                          9'h1F8, 9'h03F, 9'h1B6, 9'h0DB};

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  logic               in_ready_o;
  svt_in_t            in_data_i   = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  svt_out_t           out_data_o;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic signed [15:0] cfg_data_i  = '0;

  svt_out_t           thr_expect_q [$];
  logic signed [15:0] k_cur = KReset;
  int                 idle_pct  = 0;
  int                 stall_pct = 0;
  int                 mism      = 0;
  int                 cyc       = 0;
  dir_row_t           dir_tbl [NumDir];

  sauvola_threshold_3x3 u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic svt_out_t sauvola_thresh(input svt_in_t w, input logic signed [15:0] k);
    logic [71:0]       flat;
    longint            acc;
    longint            mean;
    longint            d;
    longint            num;
    longint unsigned   dsum;
    longint unsigned   rad;
    longint unsigned   root;
    longint unsigned   trial;
    longint            thr;
    svt_out_t          r;
    flat = w[80:9];
    acc  = 0;
    dsum = 0;
    for (int i = 0; i < 9; i++) begin
      if (w.present_mask[i]) acc += longint'(flat[71-8*i -: 8]);
    end
    mean = acc / 9;
    for (int i = 0; i < 9; i++) begin
      if (w.present_mask[i]) begin
        d = longint'(flat[71-8*i -: 8]) - mean;
        dsum += longint'(d * d);
      end
    end
    rad  = (dsum * 65536) / 9;
    root = 0;
    for (int b = 20; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= rad) root = trial;
    end
    num = mean * ((longint'(1) << 27) + longint'(k) * (longint'(root) - 32768));
    if (num <= 0) begin
      thr = 0;
    end else begin
      thr = num >>> 27;
      if (thr > 255) thr = 255;
    end
    r.local_threshold = thr[7:0];
    r.pixel_white     = (w.win_r1c1 > thr[7:0]);
    return r;
  endfunction

  function automatic svt_in_t rand_window();
    logic [71:0] flat;
    logic [8:0]  msk;
    int          kind;
    int          base;
    int          v;
    kind = $urandom_range(9);
    base = $urandom_range(255);
    for (int i = 0; i < 9; i++) begin
      case (kind)
        4, 5, 6: begin
          v = base + $urandom_range(16) - 8;
          if (v < 0) v = 0;
          if (v > 255) v = 255;
        end
        7: v = $urandom_range(1) ? base : 255 - base;
        8: v = $urandom_range(1) ? 255 : 0;
        9: v = base;
        default: v = $urandom_range(255);
      endcase
      flat[71-8*i -: 8] = v[7:0];
    end
    case ($urandom_range(9))
      0, 1, 2, 3, 4, 5: msk = 9'h1FF;
      6, 7:             msk = 9'($urandom_range(511));
      8:                msk = EdgeMask[$urandom_range(7)];
      default:          msk = 9'h1 << $urandom_range(9);
    endcase
    return {flat, msk};
  endfunction

  task automatic push_window(input svt_in_t w, input svt_out_t res);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    thr_expect_q.push_back(res);
  endtask

  task automatic write_k(input logic signed [15:0] val);
    in_valid_i <= 1'b0;
    while (thr_expect_q.size() != 0) @(posedge clk_i);
    repeat (PipeLat) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    k_cur = val;
  endtask

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk_i) begin
    svt_out_t exp_r;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (thr_expect_q.size() == 0) begin
        mism++;
        if (mism <= 10) $display("unexpected item: thr=%0d white=%0b",
                                 out_data_o.local_threshold, out_data_o.pixel_white);
      end else begin
        exp_r = thr_expect_q.pop_front();
        if (out_data_o.local_threshold !== exp_r.local_threshold ||
            out_data_o.pixel_white !== exp_r.pixel_white) begin
          mism++;
          if (mism <= 10) $display("mismatch: thr exp %0d got %0d, white exp %0b got %0b",
                                   exp_r.local_threshold, out_data_o.local_threshold,
                                   exp_r.pixel_white, out_data_o.pixel_white);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cyc++;
    if (cyc > CycLimit) begin
      $display("timeout after %0d cycles", cyc);
      $display("** sauvola_threshold_3x3: FAILED **");
      $finish;
    end
  end

  initial begin
    logic signed [15:0] k_tbl [8];
    int                 idle_tbl [4];
    int                 stall_tbl [4];
    svt_in_t            w;

    dir_tbl = '{
      '{16'sd819, {72'h00_00_00_00_00_00_00_00_00, 9'h1FF}, 1'b1, {8'd0, 1'b0}},
      '{16'sd819, {72'hFF_FF_FF_FF_FF_FF_FF_FF_FF, 9'h1FF}, 1'b1, {8'd204, 1'b1}},
      '{16'sd819, {72'h00_00_00_00_FF_00_00_00_00, 9'h000}, 1'b1, {8'd0, 1'b1}},
      '{16'sd819, {72'h00_FF_00_FF_00_FF_00_FF_00, 9'h1FF}, 1'b0, {8'd0, 1'b0}},
      '{16'sd819, {72'hFF_00_FF_00_FF_00_FF_00_FF, 9'h1FF}, 1'b0, {8'd0, 1'b0}},
      '{16'sd819, {72'h0A_0A_0A_0A_FF_0A_0A_0A_0A, 9'h1EF}, 1'b0, {8'd0, 1'b0}},
      '{16'sd819, {72'hFF_FF_FF_FF_C8_FF_FF_FF_FF, 9'h010}, 1'b0, {8'd0, 1'b0}},
      '{16'sd819, {72'h12_34_56_78_9A_BC_DE_F0_11, 9'h1B0}, 1'b0, {8'd0, 1'b0}},
      '{16'sd819, {72'h80_80_80_40_60_A0_20_E0_C0, 9'h1F8}, 1'b0, {8'd0, 1'b0}},
      '{16'sd819, {72'h01_02_04_08_10_20_40_80_FF, 9'h1FF}, 1'b0, {8'd0, 1'b0}},
      '{16'sd819, {72'hFE_FD_FB_F7_EF_DF_BF_7F_00, 9'h155}, 1'b0, {8'd0, 1'b0}},
      '{16'sd0,   {72'h64_64_64_64_64_64_64_64_64, 9'h1FF}, 1'b1, {8'd100, 1'b0}},
      '{16'sd0,   {72'h09_09_09_09_09_09_09_09_09, 9'h1FF}, 1'b1, {8'd9, 1'b0}},
      '{16'sd0,   {72'hFF_FF_FF_FF_09_FF_FF_FF_FF, 9'h010}, 1'b1, {8'd1, 1'b1}},
      '{16'sd0,   {72'hFF_FF_FF_FF_08_FF_FF_FF_FF, 9'h010}, 1'b1, {8'd0, 1'b1}},
      '{16'sd0,   {72'hFF_FF_FF_FF_FF_FF_FF_FF_FF, 9'h1FF}, 1'b1, {8'd255, 1'b0}},
      '{16'sh7FFF, {72'hC8_C8_C8_C8_C8_C8_C8_C8_C8, 9'h1FF}, 1'b1, {8'd0, 1'b1}},
      '{16'sh7FFF, {72'h00_FF_00_FF_00_FF_00_FF_00, 9'h1FF}, 1'b0, {8'd0, 1'b0}},
      '{16'sh7FFF, {72'h00_00_00_00_01_00_00_00_00, 9'h000}, 1'b1, {8'd0, 1'b1}},
      '{16'sh8000, {72'h64_64_64_64_64_64_64_64_64, 9'h1FF}, 1'b1, {8'd255, 1'b0}},
      '{16'sh8000, {72'hFF_FF_FF_FF_FF_FF_FF_FF_FF, 9'h1FF}, 1'b1, {8'd255, 1'b0}},
      '{16'sh8000, {72'h1C_1C_1C_1C_1C_1C_1C_1C_1C, 9'h1FF}, 1'b1, {8'd252, 1'b0}},
      '{16'sh8000, {72'h10_30_50_70_90_B0_D0_F0_FF, 9'h1FF}, 1'b0, {8'd0, 1'b0}},
      '{16'sd4096, {72'h32_32_32_32_32_32_32_32_32, 9'h1FF}, 1'b1, {8'd0, 1'b1}},
      '{16'sd4096, {72'h00_FF_00_FF_00_FF_00_FF_00, 9'h1FF}, 1'b0, {8'd0, 1'b0}}
    };
    k_tbl     = '{16'sh8000, 16'sh7FFF, 16'sd819, 16'sd4096, 16'sd0, 16'shF000,
                  16'sd0, 16'sd0};
    idle_tbl  = '{0, 82, 0, 34};
    stall_tbl = '{0, 0, 82, 34};

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int r = 0; r < NumDir; r++) begin
      if (dir_tbl[r].k !== k_cur) write_k(dir_tbl[r].k);
      push_window(dir_tbl[r].win,
                  dir_tbl[r].typed ? dir_tbl[r].res : sauvola_thresh(dir_tbl[r].win, k_cur));
    end

    for (int s = 0; s < 8; s++) begin
      if (s >= 6) k_tbl[s] = 16'($urandom_range(65535));
      write_k(k_tbl[s]);
      idle_pct  = idle_tbl[s / 2];
      stall_pct = stall_tbl[s / 2];
      for (int n = 0; n < NumRand; n++) begin
        w = rand_window();
        push_window(w, sauvola_thresh(w, k_cur));
      end
    end
    in_valid_i <= 1'b0;

    while (thr_expect_q.size() != 0) @(posedge clk_i);
    repeat (PipeLat * 2) @(posedge clk_i);
    if (thr_expect_q.size() != 0) begin
      $display("%0d expected items never arrived", thr_expect_q.size());
      mism += thr_expect_q.size();
    end
    if (mism == 0) begin
      $display("** sauvola_threshold_3x3: PASSED **");
    end else begin
      $display("** sauvola_threshold_3x3: FAILED **");
    end
    $finish;
  end

endmodule
